// ----- sv/hmfp_pkg.sv -----
package hmfp_pkg;

  // fixed field sizes of a hello message
  localparam int unsigned VERSION_BYTES = 2;
  localparam int unsigned RANDOM_BYTES  = 32;
  localparam int unsigned CHOSEN_SUITE_BYTES = 2;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [ADDR_W-3:0] REG_HELLO_KIND = 1'b0;

  // hello kinds
  localparam logic KIND_CLIENT = 1'b0;
  localparam logic KIND_SERVER = 1'b1;

  // field being parsed, also the tag given to each byte
  typedef enum logic [3:0] {
    PH_VERSION    = 4'd0,
    PH_RANDOM     = 4'd1,
    PH_SIDLEN     = 4'd2,
    PH_SID        = 4'd3,
    PH_SUITELEN   = 4'd4,
    PH_SUITES     = 4'd5,
    PH_CHOSEN     = 4'd6,
    PH_COMPLEN    = 4'd7,
    PH_COMPS      = 4'd8,
    PH_CHOSENCOMP = 4'd9,
    PH_EXTLEN     = 4'd10,
    PH_EXT        = 4'd11,
    PH_TRAIL      = 4'd12
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [7:0]  byte_out;
    logic [15:0] offset_in_field;
    logic        field_last;
    logic [14:0] suite_count;
    logic        extensions_present;
    logic        truncated;
  } out_rsp_t;

  // held request between the input register and the parser
  typedef struct packed {
    logic    valid;
    in_req_t req;
  } stage_t;

endpackage

// ----- sv/hmfp_in_stage.sv -----
module hmfp_in_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hmfp_pkg::in_req_t in_req_i,
  input  logic             advance_i,
  output hmfp_pkg::stage_t stage_o
);
  import hmfp_pkg::*;

  logic    valid_q;
  in_req_t req_q;

  // free when empty or when the held request moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.req   = req_q;

endmodule

// ----- sv/hmfp_parser.sv -----
module hmfp_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               fire_i,
  input  hmfp_pkg::in_req_t  req_i,
  input  logic               hello_kind_i,
  output hmfp_pkg::out_rsp_t rsp_o
);
  import hmfp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] cnt_q, cnt_d;
  logic [15:0] flen_q, flen_d;
  logic [7:0]  lhi_q, lhi_d;
  logic [14:0] scnt_q, scnt_d;
  logic        ext_q, ext_d;

  logic [7:0]  b;
  logic        last;
  logic [16:0] cnt_inc;
  logic        reach_len;
  logic [15:0] len16;
  phase_e      after_sid;
  phase_e      tag;
  phase_e      next;
  logic        done;
  logic        is_trail;
  logic        complete;
  logic        len_second;
  logic [14:0] scnt_now;

  assign b          = req_i.data_byte;
  assign last       = req_i.last_byte;
  assign cnt_inc    = {1'b0, cnt_q} + 17'd1;
  assign reach_len  = cnt_inc >= {1'b0, flen_q};
  assign len16      = {lhi_q, b};
  assign after_sid  = (hello_kind_i == KIND_SERVER) ? PH_CHOSEN : PH_SUITELEN;
  assign len_second = cnt_q != 16'd0;

  // field decode: tag, completion and following field
  always_comb begin
    tag  = phase_q;
    next = phase_q;
    done = 1'b0;
    unique case (phase_q)
      PH_VERSION: begin
        done = cnt_inc >= 17'(VERSION_BYTES);
        next = PH_RANDOM;
      end
      PH_RANDOM: begin
        done = cnt_inc >= 17'(RANDOM_BYTES);
        next = PH_SIDLEN;
      end
      PH_SIDLEN: begin
        done = 1'b1;
        next = (b != 8'd0) ? PH_SID : after_sid;
      end
      PH_SID: begin
        done = reach_len;
        next = after_sid;
      end
      PH_SUITELEN: begin
        done = len_second;
        next = (len16 != 16'd0) ? PH_SUITES : PH_COMPLEN;
      end
      PH_SUITES: begin
        done = reach_len;
        next = PH_COMPLEN;
      end
      PH_CHOSEN: begin
        done = cnt_inc >= 17'(CHOSEN_SUITE_BYTES);
        next = PH_CHOSENCOMP;
      end
      PH_COMPLEN: begin
        done = 1'b1;
        next = (b != 8'd0) ? PH_COMPS : PH_EXTLEN;
      end
      PH_COMPS: begin
        done = reach_len;
        next = PH_EXTLEN;
      end
      PH_CHOSENCOMP: begin
        done = 1'b1;
        next = PH_EXTLEN;
      end
      PH_EXTLEN: begin
        done = len_second;
        next = (len16 != 16'd0) ? PH_EXT : PH_TRAIL;
      end
      PH_EXT: begin
        done = reach_len;
        next = PH_TRAIL;
      end
      default: begin
        tag  = PH_TRAIL;
        done = last;
        next = PH_TRAIL;
      end
    endcase
  end

  assign is_trail = tag == PH_TRAIL;
  assign complete = is_trail || (done && (next == PH_EXTLEN || next == PH_TRAIL));

  // suite count including an update made by this byte
  assign scnt_now = (phase_q == PH_SUITELEN && len_second) ? len16[15:1] : scnt_q;

  // result fields
  always_comb begin
    rsp_o.field_tag          = tag;
    rsp_o.byte_out           = b;
    rsp_o.offset_in_field    = cnt_q;
    rsp_o.field_last         = done;
    rsp_o.suite_count        = (hello_kind_i == KIND_SERVER) ? 15'd0 : scnt_now;
    rsp_o.extensions_present = ext_q || (phase_q == PH_EXTLEN);
    rsp_o.truncated          = last && !complete;
  end

  // next parser state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    flen_d  = flen_q;
    lhi_d   = lhi_q;
    scnt_d  = scnt_now;
    ext_d   = ext_q;
    // captured lengths
    unique case (phase_q)
      PH_SIDLEN, PH_COMPLEN: flen_d = {8'd0, b};
      PH_SUITELEN: begin
        if (len_second) begin
          flen_d = len16;
        end else begin
          lhi_d = b;
        end
      end
      PH_EXTLEN: begin
        ext_d = 1'b1;
        if (len_second) begin
          flen_d = len16;
        end else begin
          lhi_d = b;
        end
      end
      default: ;
    endcase
    // phase and byte position
    priority if (is_trail) begin
      phase_d = PH_TRAIL;
      cnt_d   = (cnt_q != 16'hFFFF) ? cnt_inc[15:0] : cnt_q;
    end else if (done) begin
      phase_d = next;
      cnt_d   = 16'd0;
    end else begin
      cnt_d = cnt_inc[15:0];
    end
    // message end starts over
    if (last) begin
      phase_d = PH_VERSION;
      cnt_d   = 16'd0;
      flen_d  = 16'd0;
      lhi_d   = 8'd0;
      scnt_d  = 15'd0;
      ext_d   = 1'b0;
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      cnt_q   <= 16'd0;
      flen_q  <= 16'd0;
      lhi_q   <= 8'd0;
      scnt_q  <= 15'd0;
      ext_q   <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      flen_q  <= flen_d;
      lhi_q   <= lhi_d;
      scnt_q  <= scnt_d;
      ext_q   <= ext_d;
    end
  end

endmodule

// ----- sv/hmfp_out_stage.sv -----
module hmfp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  hmfp_pkg::out_rsp_t rsp_i,
  output logic               advance_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hmfp_pkg::out_rsp_t out_rsp_o
);
  import hmfp_pkg::*;

  logic     valid_q;
  out_rsp_t rsp_q;

  // result register can take a new result when empty or being drained
  assign advance_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && valid_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

// ----- sv/hello_message_field_parser_unit.sv -----
// Hello message field parser: tags each byte of a client or server hello body
// with the field it belongs to.
// Input channel: in_valid_i / in_ready_o carry one request per byte
// (in_req_i: data byte and a last-byte mark). Output channel: out_valid_o /
// out_ready_i carry one result per byte (out_rsp_o: field tag, byte, offset in
// field, field end, suite count, extensions seen, truncation flag).
// Configuration: APB-style register hello_kind at address 0 (0 client,
// 1 server); write it only while no bytes are in flight.
// Path: an input register, combinational field decode and a result register;
// a result is offered once the result register has taken it.
// Throughput: one byte per cycle, sustained as long as results are taken.
// Stall: when out_ready_i is low the result register holds; the input
// register takes one more byte only if it was empty; once it holds a byte,
// in_ready_o is low until the result drains. Nothing is dropped or repeated.
// Reset: clears both valid flags, hello_kind to client, and the parser to
// the version field. After a byte marked last the parser restarts at the
// version field for the next message.
module hello_message_field_parser_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [hmfp_pkg::ADDR_W-1:0]          paddr,
  input  logic [hmfp_pkg::DATA_W-1:0]          pwdata,
  output logic [hmfp_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  // byte input
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  hmfp_pkg::in_req_t                    in_req_i,
  // tagged byte output
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hmfp_pkg::out_rsp_t                   out_rsp_o
);
  import hmfp_pkg::*;

  logic     hello_kind_q;
  logic     reg_sel;
  stage_t   stage;
  logic     advance;
  logic     fire;
  out_rsp_t rsp;

  // register decode by word index
  assign reg_sel = paddr[ADDR_W-1:2] == REG_HELLO_KIND;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {{(DATA_W-1){1'b0}}, hello_kind_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hello_kind_q <= KIND_CLIENT;
    end else if (psel && penable && pwrite && reg_sel) begin
      hello_kind_q <= pwdata[0];
    end
  end

  // input register
  hmfp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .advance_i  (advance),
    .stage_o    (stage)
  );

  assign fire = stage.valid && advance;

  // field decode and parser state
  hmfp_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .req_i        (stage.req),
    .hello_kind_i (hello_kind_q),
    .rsp_o        (rsp)
  );

  // result register
  hmfp_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (stage.valid),
    .rsp_i       (rsp),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
